FILE: sv/lmx_pkg.sv
package lmx_pkg;

    // configuration reset values
    localparam logic [63:0] SEED_RESET   = 64'h3FD999999999999A;
    localparam logic [63:0] GAIN_RESET   = 64'h400F333333333333;
    localparam int          WARMUP_W     = 20;
    localparam logic [WARMUP_W-1:0] WARMUP_RESET = 20'd5000;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // double constants
    localparam logic [63:0] ONE_BITS    = 64'h3FF0000000000000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;

    // working mantissa width of the float unit: carry, 53 bits, 56 round bits
    localparam int MW = 110;

    typedef enum logic {
        FOP_SUB = 1'b0,
        FOP_MUL = 1'b1
    } t_fop;

    // one queued byte, classified by the front
    typedef struct packed {
        logic [7:0] data_byte;
        logic       som;
        logic       step;
        logic       warm;
        logic [1:0] pos;
    } t_item;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fpu_rsp;

endpackage

FILE: sv/lmx_if.sv
interface lmx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_message;

    modport source (output valid, output data_byte, output start_of_message, input ready);
    modport sink (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface lmx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

FILE: sv/lmx_front.sv
module lmx_front #(
    parameter int QDEPTH = lmx_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lmx_in_if.sink         i_in,
    input  logic           i_pop,
    output logic           o_q_valid,
    output lmx_pkg::t_item o_item
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    lmx_pkg::t_item r_mem [QDEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [AW:0]    r_count;
    logic [1:0]     r_pos;
    logic           r_warmed;

    logic           push;
    logic [1:0]     pos_eff;
    lmx_pkg::t_item item;

    assign i_in.ready = (r_count != (AW+1)'(QDEPTH));
    assign push       = i_in.valid & i_in.ready;

    // classify: byte position, map step, warmup
    always_comb begin
        pos_eff        = i_in.start_of_message ? 2'd0 : r_pos;
        item.data_byte = i_in.data_byte;
        item.som       = i_in.start_of_message;
        item.step      = (pos_eff == 2'd0);
        item.warm      = i_in.start_of_message | ~r_warmed;
        item.pos       = pos_eff;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
            r_pos    <= 2'd0;
            r_warmed <= 1'b0;
        end else begin
            if (push) begin
                r_wptr   <= (r_wptr == AW'(QDEPTH-1)) ? '0 : r_wptr + 1'b1;
                r_pos    <= pos_eff + 2'd1;
                r_warmed <= 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(QDEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_item    = r_mem[r_rptr];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

FILE: sv/lmx_fpu.sv
module lmx_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lmx_pkg::t_fpu_req i_req,
    output lmx_pkg::t_fpu_rsp o_rsp
);

    localparam int MW  = lmx_pkg::MW;
    localparam int LOW = MW - 54;

    typedef enum logic [6:0] {
        F_IDLE   = 7'b0000001,
        F_MUL    = 7'b0000010,
        F_ALIGN  = 7'b0000100,
        F_ADD    = 7'b0001000,
        F_NORM   = 7'b0010000,
        F_DENORM = 7'b0100000,
        F_ROUND  = 7'b1000000
    } t_fstate;

    t_fstate            r_state;
    logic               r_done;
    logic [63:0]        r_res;
    logic               r_sa, r_sb, r_s, r_sub;
    logic [10:0]        r_ea, r_eb;
    logic [52:0]        r_ma, r_mb;
    logic signed [13:0] r_e;
    logic [MW-1:0]      r_m, r_m2;
    logic [1:0]         r_cnt;

    // operand unpack
    logic [10:0] a_ef, b_ef, a_e, b_e;
    logic [52:0] a_m, b_m;
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        spec;
    logic [63:0] spec_res;

    always_comb begin
        a_ef   = i_req.a[62:52];
        b_ef   = i_req.b[62:52];
        a_nan  = (a_ef == 11'h7FF) && (i_req.a[51:0] != '0);
        b_nan  = (b_ef == 11'h7FF) && (i_req.b[51:0] != '0);
        a_inf  = (a_ef == 11'h7FF) && (i_req.a[51:0] == '0);
        b_inf  = (b_ef == 11'h7FF) && (i_req.b[51:0] == '0);
        a_zero = (a_ef == '0) && (i_req.a[51:0] == '0);
        b_zero = (b_ef == '0) && (i_req.b[51:0] == '0);
        a_m    = {a_ef != '0, i_req.a[51:0]};
        b_m    = {b_ef != '0, i_req.b[51:0]};
        a_e    = (a_ef == '0) ? 11'd1 : a_ef;
        b_e    = (b_ef == '0) ? 11'd1 : b_ef;
        sa     = i_req.a[63];
        // subtract is an add of the negated b
        sb     = (i_req.op == lmx_pkg::FOP_SUB) ? ~i_req.b[63] : i_req.b[63];

        spec     = 1'b1;
        spec_res = '0;
        if (a_nan) begin
            spec_res = i_req.a | 64'h0008000000000000;
        end else if (b_nan) begin
            spec_res = i_req.b | 64'h0008000000000000;
        end else if (i_req.op == lmx_pkg::FOP_MUL) begin
            if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                spec_res = lmx_pkg::DEFAULT_NAN;
            end else if (a_inf || b_inf) begin
                spec_res = {sa ^ sb, 11'h7FF, 52'b0};
            end else if (a_zero || b_zero) begin
                spec_res = {sa ^ sb, 63'b0};
            end else begin
                spec = 1'b0;
            end
        end else begin
            if (a_inf && b_inf && (sa != sb)) begin
                spec_res = lmx_pkg::DEFAULT_NAN;
            end else if (a_inf) begin
                spec_res = i_req.a;
            end else if (b_inf) begin
                spec_res = {sb, 11'h7FF, 52'b0};
            end else if (a_zero && b_zero) begin
                spec_res = {sa & sb, 63'b0};
            end else if (a_zero) begin
                spec_res = {sb, i_req.b[62:0]};
            end else if (b_zero) begin
                spec_res = i_req.a;
            end else begin
                spec = 1'b0;
            end
        end
    end

    // partial products, 27 x 27 per cycle
    logic [26:0]   opa, opb;
    logic [53:0]   pp;
    logic [5:0]    pp_sh;
    logic [MW-1:0] pp_ext;

    always_comb begin
        opa    = r_cnt[0] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        opb    = r_cnt[1] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
        pp     = opa * opb;
        pp_sh  = 6'd4 + (r_cnt[0] ? 6'd27 : 6'd0) + (r_cnt[1] ? 6'd27 : 6'd0);
        pp_ext = MW'(pp) << pp_sh;
    end

    // alignment of the smaller addend
    logic          a_big, sbig;
    logic [10:0]   ebig, esm, d;
    logic [52:0]   mbig, msm;
    logic [MW-1:0] m_big_w, m_sm_w, m_sm_sh;

    always_comb begin
        a_big   = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
        ebig    = a_big ? r_ea : r_eb;
        esm     = a_big ? r_eb : r_ea;
        mbig    = a_big ? r_ma : r_mb;
        msm     = a_big ? r_mb : r_ma;
        sbig    = a_big ? r_sa : r_sb;
        d       = ebig - esm;
        m_big_w = {1'b0, mbig, LOW'(0)};
        m_sm_w  = {1'b0, msm, LOW'(0)};
        if (d >= 11'(MW)) begin
            m_sm_sh = MW'(1);
        end else begin
            m_sm_sh = (m_sm_w >> d)
                    | MW'(|(m_sm_w & ~({MW{1'b1}} << d)));
        end
    end

    // leading zeros among the top eight bits
    logic [7:0] top8;
    logic [3:0] lz;

    always_comb begin
        top8 = r_m[MW-1 -: 8];
        lz   = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (top8[i]) lz = 4'(7 - i);
        end
    end

    // subnormal shift with sticky
    logic [13:0]   amt;
    logic [MW-1:0] m_dn;

    always_comb begin
        amt = 14'(14'sd1 - r_e);
        if (amt >= 14'(MW)) begin
            m_dn = MW'(1);
        end else begin
            m_dn = (r_m >> amt[6:0])
                 | MW'(|(r_m & ~({MW{1'b1}} << amt[6:0])));
        end
    end

    // round to nearest even and pack
    logic [52:0]        mant;
    logic               g, st, inc;
    logic [53:0]        mant_r;
    logic signed [13:0] e_m1;
    logic [64:0]        tot;
    logic [63:0]        rnd_res;

    always_comb begin
        mant    = r_m[MW-1 -: 53];
        g       = r_m[LOW];
        st      = |r_m[LOW-1:0];
        inc     = g & (st | mant[0]);
        mant_r  = {1'b0, mant} + 54'(inc);
        e_m1    = r_e - 14'sd1;
        tot     = {e_m1[12:0], 52'b0} + 65'(mant_r);
        if (tot[64:52] >= 13'd2047) begin
            rnd_res = {r_s, 11'h7FF, 52'b0};
        end else begin
            rnd_res = {r_s, tot[62:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        if (spec) begin
                            r_res  <= spec_res;
                            r_done <= 1'b1;
                        end else if (i_req.op == lmx_pkg::FOP_MUL) begin
                            r_state <= F_MUL;
                        end else begin
                            r_state <= F_ALIGN;
                        end
                    end
                end
                F_MUL: begin
                    if (r_cnt == 2'd3) r_state <= F_NORM;
                end
                F_ALIGN: r_state <= F_ADD;
                F_ADD: begin
                    if ((r_sub ? r_m - r_m2 : r_m + r_m2) == '0) begin
                        r_res   <= '0;
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else begin
                        r_state <= F_NORM;
                    end
                end
                F_NORM: begin
                    if (r_m[MW-1]) begin
                        r_state <= (r_e <= 14'sd0) ? F_DENORM : F_ROUND;
                    end
                end
                F_DENORM: r_state <= F_ROUND;
                F_ROUND: begin
                    r_res   <= rnd_res;
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_sa  <= sa;
                r_sb  <= sb;
                r_ea  <= a_e;
                r_eb  <= b_e;
                r_ma  <= a_m;
                r_mb  <= b_m;
                r_s   <= sa ^ sb;
                r_e   <= $signed({3'b0, a_e}) + $signed({3'b0, b_e}) - 14'sd1022;
                r_m   <= '0;
                r_cnt <= 2'd0;
            end
            F_MUL: begin
                r_m   <= r_m + pp_ext;
                r_cnt <= r_cnt + 2'd1;
            end
            F_ALIGN: begin
                r_m   <= m_big_w;
                r_m2  <= m_sm_sh;
                r_s   <= sbig;
                r_sub <= (r_sa != r_sb);
                r_e   <= $signed({3'b0, ebig}) + 14'sd1;
            end
            F_ADD: begin
                r_m <= r_sub ? r_m - r_m2 : r_m + r_m2;
            end
            F_NORM: begin
                if (!r_m[MW-1]) begin
                    r_m <= r_m << lz;
                    r_e <= r_e - $signed({10'b0, lz});
                end
            end
            F_DENORM: begin
                r_m <= m_dn;
                r_e <= 14'sd1;
            end
            default: begin
                r_m <= r_m;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    a_round_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_ROUND) |=> r_done)
        else $error("rounding did not complete the operation");

    a_round_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_ROUND) |-> (r_m[MW-1] || (r_e == 14'sd1)))
        else $error("mantissa not normalized at rounding");

endmodule

FILE: sv/lmx_back.sv
module lmx_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  lmx_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [63:0]                   i_seed,
    input  logic [63:0]                   i_gain,
    input  logic [lmx_pkg::WARMUP_W-1:0]  i_warmup,
    lmx_out_if.source                     o_out
);

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_CHK    = 6'b000010,
        B_SUBW   = 6'b000100,
        B_MUL1W  = 6'b001000,
        B_MUL2W  = 6'b010000,
        B_EMIT   = 6'b100000
    } t_bstate;

    t_bstate                      r_state;
    lmx_pkg::t_item               r_item;
    logic [63:0]                  r_x;
    logic [31:0]                  r_key;
    logic [lmx_pkg::WARMUP_W-1:0] r_wcnt;
    logic                         r_need;
    logic                         r_final;
    logic                         r_ovalid;
    logic [7:0]                   r_obyte;

    lmx_pkg::t_fpu_req fpu_req;
    lmx_pkg::t_fpu_rsp fpu_rsp;
    logic              emit_ok;

    lmx_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    // map step: 1 - x, then x * that, then times gain
    always_comb begin
        fpu_req.start = 1'b0;
        fpu_req.op    = lmx_pkg::FOP_SUB;
        fpu_req.a     = lmx_pkg::ONE_BITS;
        fpu_req.b     = r_x;
        unique case (r_state)
            B_CHK: begin
                fpu_req.start = (r_wcnt != '0) || r_need;
            end
            B_SUBW: begin
                fpu_req.start = fpu_rsp.done;
                fpu_req.op    = lmx_pkg::FOP_MUL;
                fpu_req.a     = r_x;
                fpu_req.b     = fpu_rsp.res;
            end
            B_MUL1W: begin
                fpu_req.start = fpu_rsp.done;
                fpu_req.op    = lmx_pkg::FOP_MUL;
                fpu_req.a     = fpu_rsp.res;
                fpu_req.b     = i_gain;
            end
            default: begin
                fpu_req.start = 1'b0;
            end
        endcase
    end

    assign o_pop   = (r_state == B_IDLE) && i_q_valid;
    assign emit_ok = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_x      <= lmx_pkg::SEED_RESET;
            r_key    <= '0;
            r_wcnt   <= '0;
            r_need   <= 1'b0;
            r_final  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready && !((r_state == B_EMIT) && emit_ok)) r_ovalid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        if (i_item.som) r_x <= i_seed;
                        r_wcnt  <= i_item.warm ? i_warmup : '0;
                        r_need  <= i_item.step;
                        r_state <= B_CHK;
                    end
                end
                B_CHK: begin
                    if (r_wcnt != '0) begin
                        r_final <= 1'b0;
                        r_state <= B_SUBW;
                    end else if (r_need) begin
                        r_final <= 1'b1;
                        r_need  <= 1'b0;
                        r_state <= B_SUBW;
                    end else begin
                        r_state <= B_EMIT;
                    end
                end
                B_SUBW: begin
                    if (fpu_rsp.done) r_state <= B_MUL1W;
                end
                B_MUL1W: begin
                    if (fpu_rsp.done) r_state <= B_MUL2W;
                end
                B_MUL2W: begin
                    if (fpu_rsp.done) begin
                        r_x <= fpu_rsp.res;
                        if (r_final) begin
                            r_key <= fpu_rsp.res[31:0];
                        end else begin
                            r_wcnt <= r_wcnt - 1'b1;
                        end
                        r_state <= B_CHK;
                    end
                end
                B_EMIT: begin
                    if (emit_ok) begin
                        r_ovalid <= 1'b1;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
        if ((r_state == B_EMIT) && emit_ok) begin
            r_obyte <= r_item.data_byte ^ r_key[{r_item.pos, 3'b000} +: 8];
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;

    a_key_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL2W && fpu_rsp.done && r_final)
        |=> (r_key == $past(fpu_rsp.res[31:0])))
        else $error("key word not taken from the final map step");

    a_chk_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHK && r_wcnt == '0 && !r_need) |=> (r_state == B_EMIT))
        else $error("byte with no pending map step did not go to emit");

endmodule

FILE: sv/logistic_map_xor_stream_cipher.sv
// channel   dir  payload                            transfer when
// i_in      in   data_byte[7:0], start_of_message   i_in.valid & i_in.ready
// o_out     out  out_byte[7:0]                      o_out.valid & o_out.ready
// cfg       in   i_cfg_idx[1:0], i_cfg_data[63:0]   i_cfg_we
//
// a byte that draws no new key word passes the back end states idle, check, emit
// a byte at word position 0 adds one map step: three passes through the shared
// double unit (1 - x, x * t, t * gain), each finished straight from idle when an
// operand is zero, infinite or nan
// the first byte of a message or after reset also runs warmup_count map steps first
// reset is synchronous, active low; the queue lets the front take bytes while
// the back end iterates, and the output register holds a result under stall
module logistic_map_xor_stream_cipher #(
    parameter int QUEUE_DEPTH = lmx_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmx_in_if.sink      i_in,
    lmx_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    // register indexes
    localparam logic [1:0] CFG_SEED   = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_WARMUP = 2'd2;

    logic [63:0]                  r_seed;
    logic [63:0]                  r_gain;
    logic [lmx_pkg::WARMUP_W-1:0] r_warmup;

    logic           q_valid;
    logic           q_pop;
    lmx_pkg::t_item q_item;

    // configuration registers, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= lmx_pkg::SEED_RESET;
            r_gain   <= lmx_pkg::GAIN_RESET;
            r_warmup <= lmx_pkg::WARMUP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED:   r_seed   <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data;
                CFG_WARMUP: r_warmup <= i_cfg_data[lmx_pkg::WARMUP_W-1:0];
                default:    r_seed   <= r_seed;
            endcase
        end
    end

    // front: takes each transfer, tags word position, map step and warmup
    lmx_front #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_pop     (q_pop),
        .o_q_valid (q_valid),
        .o_item    (q_item)
    );

    // back: runs the map on the double unit and xors the key byte
    lmx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .i_seed    (r_seed),
        .i_gain    (r_gain),
        .i_warmup  (r_warmup),
        .o_out     (o_out)
    );

endmodule
